FILE: sv/sensor_row_marker_descrambler_unit_defines.svh
// ----------------------------------------------------------------------------
// sensor_row_marker_descrambler_unit_defines
// assertion macros shared by the descrambler modules
// ----------------------------------------------------------------------------
`ifndef SENSOR_ROW_MARKER_DESCRAMBLER_UNIT_DEFINES_SVH
`define SENSOR_ROW_MARKER_DESCRAMBLER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SRMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define SRMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/srmd_pkg.sv
// ----------------------------------------------------------------------------
// srmd_pkg
// widths, codes and types of the sensor row marker descrambler
// ----------------------------------------------------------------------------
package srmd_pkg;

	localparam int BYTE_W   = 8;
	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 12;
	localparam int MODE_W   = 4;
	localparam int PIX_W    = 12;
	localparam int ADDR_W   = 24;
	localparam int PROD_W   = WIDTH_W + HEIGHT_W;
	localparam int MCOL_W   = WIDTH_W + 1;
	localparam int SUM_W    = PROD_W + 1;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int NIB_W    = 4;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd1024;
	localparam logic [MODE_W-1:0]   MODE_RESET   = 4'd0;
	localparam logic [MODE_W-1:0]   MODE_INTERLEAVE = 4'd3;

	// top nibble codes of a stream word
	localparam logic [NIB_W-1:0] NIB_ROW_A = 4'hE;
	localparam logic [NIB_W-1:0] NIB_ROW_B = 4'hA;
	localparam logic [NIB_W-1:0] NIB_SKIP  = 4'hF;

	// register index, paddr[3:2]
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	typedef struct packed {
		logic [WIDTH_W-1:0]  width;
		logic [HEIGHT_W-1:0] height;
		logic [MODE_W-1:0]   mode;
	} cfg_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] row;
		logic [WIDTH_W-1:0]  col;
		logic [PIX_W-1:0]    value;
	} pix_t;

endpackage

FILE: sv/srmd_in_if.sv
// ----------------------------------------------------------------------------
// srmd_in_if
// raw byte request channel
// ----------------------------------------------------------------------------
interface srmd_in_if
	import srmd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              start_of_frame;

	modport source (output valid, output data_byte, output start_of_frame, input ready);
	modport sink (input valid, input data_byte, input start_of_frame, output ready);
endinterface

FILE: sv/srmd_out_if.sv
// ----------------------------------------------------------------------------
// srmd_out_if
// addressed pixel request channel
// ----------------------------------------------------------------------------
interface srmd_out_if
	import srmd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] pixel_address;
	logic [PIX_W-1:0]  pixel_value;

	modport source (output valid, output pixel_address, output pixel_value, input ready);
	modport sink (input valid, input pixel_address, input pixel_value, output ready);
endinterface

FILE: sv/srmd_cfg.sv
// ----------------------------------------------------------------------------
// srmd_cfg
// apb register file: frame width, frame height, order mode, frame size
// ----------------------------------------------------------------------------
module srmd_cfg
	import srmd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg,
	output logic [PROD_W-1:0]  limit
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [MODE_W-1:0]   mode_q;
	logic [PROD_W-1:0]   limit_q;
	logic                wr;
	logic [1:0]          idx;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			mode_q   <= MODE_RESET;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// frame size in pixels, registered from the width and height registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= PROD_W'(WIDTH_RESET) * PROD_W'(HEIGHT_RESET);
		end else begin
			limit_q <= PROD_W'(width_q) * PROD_W'(height_q);
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_MODE:   prdata = PDATA_W'(mode_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.width  = width_q;
	assign cfg.height = height_q;
	assign cfg.mode   = mode_q;
	assign limit      = limit_q;

endmodule

FILE: sv/srmd_decode.sv
// ----------------------------------------------------------------------------
// srmd_decode
// byte pairing, marker decode, row and column tracking
// ----------------------------------------------------------------------------
`include "sensor_row_marker_descrambler_unit_defines.svh"

module srmd_decode
	import srmd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	srmd_in_if.sink    in_ch,
	input  cfg_t       cfg,
	output logic       s1_valid,
	output pix_t       s1_pix,
	input  logic       s1_ready
);

	logic [BYTE_W-1:0]   held_q;
	logic                phase_q;
	logic [WIDTH_W-1:0]  col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                valid_s1;
	pix_t                pix_s1;

	logic                acc;
	logic                sof;
	logic                phase_eff;
	logic [WIDTH_W-1:0]  col_eff;
	logic [HEIGHT_W-1:0] row_eff;
	logic [NIB_W-1:0]    nib;
	logic [PIX_W-1:0]    low12;
	logic                phase_n;
	logic [WIDTH_W-1:0]  col_n;
	logic [HEIGHT_W-1:0] row_n;
	logic                hit;

	assign in_ch.ready = !valid_s1 || s1_ready;
	assign acc         = in_ch.valid && in_ch.ready;
	assign sof         = in_ch.start_of_frame;

	assign phase_eff = sof ? 1'b0 : phase_q;
	assign col_eff   = sof ? '0 : col_q;
	assign row_eff   = sof ? '0 : row_q;
	assign nib       = in_ch.data_byte[BYTE_W-1:BYTE_W-NIB_W];
	assign low12     = {in_ch.data_byte[NIB_W-1:0], held_q};

	always_comb begin
		phase_n = 1'b0;
		col_n   = col_eff;
		row_n   = row_eff;
		hit     = 1'b0;
		if (!phase_eff) begin
			phase_n = 1'b1;
		end else if (nib == NIB_ROW_A || nib == NIB_ROW_B) begin
			row_n = low12;
			col_n = '0;
		end else if (nib != NIB_SKIP) begin
			if (col_eff < cfg.width && row_eff < cfg.height) begin
				hit   = 1'b1;
				col_n = col_eff + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			phase_q <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (acc) begin
			if (!phase_eff) begin
				held_q <= in_ch.data_byte;
			end
			phase_q <= phase_n;
			col_q   <= col_n;
			row_q   <= row_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= acc && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1.row   <= row_eff;
			pix_s1.col   <= col_eff;
			pix_s1.value <= low12;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_pix   = pix_s1;

	`SRMD_ASSERT_NEXT(a_sof_takes_low, acc && sof, phase_q, "frame start did not hold low byte")
	`SRMD_ASSERT_NEXT(a_state_holds, !acc, $stable(phase_q) && $stable(col_q) && $stable(row_q), "state moved without request")
	`SRMD_ASSERT_NOW(a_pix_on_high, acc && hit, phase_eff, "pixel decoded on a low byte")

endmodule

FILE: sv/srmd_addr.sv
// ----------------------------------------------------------------------------
// srmd_addr
// column remap, address multiply, frame bound check, output register
// ----------------------------------------------------------------------------
`include "sensor_row_marker_descrambler_unit_defines.svh"

module srmd_addr
	import srmd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic [PROD_W-1:0] limit,
	input  logic              s1_valid,
	input  pix_t              s1_pix,
	output logic              s1_ready,
	srmd_out_if.source        out_ch
);

	logic                valid_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [MCOL_W-1:0]   mcol_s2;
	logic [PIX_W-1:0]    value_s2;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PIX_W-1:0]    value_q;

	logic                en2;
	logic                en3;
	logic [WIDTH_W-1:0]  half;
	logic [MCOL_W-1:0]   mcol;
	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    sum;
	logic                keep;

	assign en3      = !out_valid_q || out_ch.ready;
	assign en2      = !valid_s2 || en3;
	assign s1_ready = en2;

	assign half = cfg.width >> 1;

	always_comb begin
		if (cfg.mode != MODE_INTERLEAVE) begin
			mcol = MCOL_W'(s1_pix.col);
		end else if (s1_pix.col < half) begin
			mcol = {s1_pix.col, 1'b0};
		end else begin
			mcol = {s1_pix.col - half, 1'b1};
		end
	end

	assign prod = PROD_W'(s1_pix.row) * PROD_W'(cfg.width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2  <= prod;
			mcol_s2  <= mcol;
			value_s2 <= s1_pix.value;
		end
	end

	assign sum  = SUM_W'(prod_s2) + SUM_W'(mcol_s2);
	assign keep = (sum < SUM_W'(limit)) && (sum[SUM_W-1:ADDR_W] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en3) begin
			out_valid_q <= valid_s2 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			addr_q  <= sum[ADDR_W-1:0];
			value_q <= value_s2;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.pixel_address = addr_q;
	assign out_ch.pixel_value   = value_q;

	`SRMD_ASSERT_NEXT(a_s2_held, valid_s2 && !en3, valid_s2, "stalled pixel lost in address stage")
	`SRMD_ASSERT_NOW(a_out_from_s2, $rose(out_valid_q), $past(valid_s2), "result without a pixel behind it")

endmodule

FILE: sv/sensor_row_marker_descrambler_unit.sv
// ----------------------------------------------------------------------------
// sensor_row_marker_descrambler_unit
// raw sensor bytes to addressed 12-bit pixels
// ----------------------------------------------------------------------------
// in_ch takes one raw byte per request with a start_of_frame flag; byte pairs
// form little-endian words. row marker words set the row, skip words vanish,
// pixel words inside the frame come out on out_ch with their frame address.
// registers on the apb port: frame_width at 0x0, frame_height at 0x4,
// order_mode at 0x8 (3 = column interleave); write them only while idle.
// a pixel is registered in the decode stage, the address stage and out_ch.
// throughput: one byte per cycle unless out_ch stalls, set by the decode
// stage, which updates row, column and byte phase in the cycle of the request.
// out_ch is driven from a register; a stall there backs up through the two
// internal stages, and in_ch stays ready while a stage ahead is empty.
// reset: registers return to 1024 x 1024, direct order; phase, row and column
// clear and no result is pending.
// ----------------------------------------------------------------------------
module sensor_row_marker_descrambler_unit
	import srmd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	srmd_in_if.sink            in_ch,
	srmd_out_if.source         out_ch
);

	cfg_t              cfg;
	logic [PROD_W-1:0] limit;
	logic              s1_valid;
	logic              s1_ready;
	pix_t              s1_pix;

	assign pready = 1'b1;

	srmd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.limit   (limit)
	);

	srmd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.s1_valid (s1_valid),
		.s1_pix   (s1_pix),
		.s1_ready (s1_ready)
	);

	srmd_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.limit    (limit),
		.s1_valid (s1_valid),
		.s1_pix   (s1_pix),
		.s1_ready (s1_ready),
		.out_ch   (out_ch)
	);

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sensor row marker descrambler
// ----------------------------------------------------------------------------
// a short directed stream covers pixel extremes, both row marker codes, skip
// words, pixels outside the frame and a dropped odd byte, then random streams
// of well-formed words mixed with stray bytes and frame starts run under
// several frame settings. every accepted byte goes through a bench-side
// descrambler and each pixel on the output channel is compared in order.
// both channels idle at random and the pixel side holds off once for a long
// stretch so that the block backs up into its byte input.
// ----------------------------------------------------------------------------
module tb_top;
	import srmd_pkg::*;

	localparam int STREAM_BYTES = 180;
	localparam int PHASES       = 10;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AFTER   = 60;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_NONE,
		EXP_PIXEL
	} exp_kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  value;
	} addr_pixel_t;

	typedef struct packed {
		logic              sof;
		logic [BYTE_W-1:0] data;
		exp_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  value;
	} stim_row_t;

	typedef struct packed {
		logic              sof;
		logic [BYTE_W-1:0] data;
	} stream_byte_t;

	localparam int DIRECTED_ROWS = 25;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b1, 8'h34, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h02, EXP_PIXEL, 24'd0,    12'h234},
		'{1'b0, 8'hFF, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h0F, EXP_PIXEL, 24'd1,    12'hFFF},
		'{1'b0, 8'h00, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h00, EXP_PIXEL, 24'd2,    12'h000},
		'{1'b0, 8'h05, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'hE0, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h11, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h12, EXP_PIXEL, 24'd5120, 12'h211},
		'{1'b0, 8'hFF, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'hFF, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h22, EXP_MODEL, 24'd0,    12'h000},
		'{1'b0, 8'hDB, EXP_MODEL, 24'd0,    12'h000},
		'{1'b0, 8'hFF, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'hAF, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h99, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h09, EXP_NONE,  24'd0,    12'h000},
		'{1'b1, 8'h77, EXP_NONE,  24'd0,    12'h000},
		'{1'b1, 8'h01, EXP_NONE,  24'd0,    12'h000},
		'{1'b0, 8'h83, EXP_PIXEL, 24'd0,    12'h301},
		'{1'b0, 8'hFF, EXP_MODEL, 24'd0,    12'h000},
		'{1'b0, 8'h9F, EXP_MODEL, 24'd0,    12'h000},
		'{1'b0, 8'h00, EXP_MODEL, 24'd0,    12'h000},
		'{1'b0, 8'hC0, EXP_MODEL, 24'd0,    12'h000}
	};

	localparam int FIXED_SETTINGS = 6;
	localparam cfg_t FIXED_CFG [FIXED_SETTINGS] = '{
		'{13'd1,    12'd1,    MODE_RESET},
		'{13'd4096, 12'd4095, MODE_INTERLEAVE},
		'{13'd7,    12'd3,    MODE_INTERLEAVE},
		'{13'd5,    12'd1,    MODE_INTERLEAVE},
		'{13'd1,    12'd4095, MODE_INTERLEAVE},
		'{13'd4096, 12'd1,    MODE_RESET}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	srmd_in_if  in_bus ();
	srmd_out_if out_bus ();

	sensor_row_marker_descrambler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_bus),
		.out_ch  (out_bus)
	);

	// bench-side descrambler state
	cfg_t                frame_cfg;
	logic [BYTE_W-1:0]   held_byte;
	logic                high_phase;
	logic [WIDTH_W-1:0]  col_count;
	logic [HEIGHT_W-1:0] cur_row;

	addr_pixel_t  pending_pixels[$];
	stream_byte_t stream_bytes[$];
	addr_pixel_t  oldest_pixel;

	int errors;
	int bytes_sent;
	int pixels_seen;
	int settings_used;
	int idle_cycles;
	bit send_burst;
	bit recv_burst;
	int send_count;
	int recv_count;
	bit held_off;

	function automatic bit descramble_byte(input logic sof, input logic [BYTE_W-1:0] b,
		output addr_pixel_t px);
		logic [15:0]       word;
		logic [NIB_W-1:0]  nib;
		int unsigned       half;
		int unsigned       mcol;
		int unsigned       full_addr;
		longint unsigned   frame_size;
		px = '0;
		if (sof) begin
			cur_row    = '0;
			col_count  = '0;
			high_phase = 1'b0;
		end
		if (!high_phase) begin
			held_byte  = b;
			high_phase = 1'b1;
			return 1'b0;
		end
		high_phase = 1'b0;
		word = {b, held_byte};
		nib  = word[15:12];
		if (nib == NIB_ROW_A || nib == NIB_ROW_B) begin
			cur_row   = word[11:0];
			col_count = '0;
			return 1'b0;
		end
		if (nib == NIB_SKIP)
			return 1'b0;
		if (col_count >= frame_cfg.width || cur_row >= frame_cfg.height)
			return 1'b0;
		mcol = 32'(col_count);
		if (frame_cfg.mode == MODE_INTERLEAVE) begin
			half = 32'(frame_cfg.width) / 2;
			if (mcol < half)
				mcol = mcol * 2;
			else
				mcol = (mcol - half) * 2 + 1;
		end
		full_addr  = 32'(cur_row) * 32'(frame_cfg.width) + mcol;
		col_count  = col_count + 1'b1;
		frame_size = 64'(frame_cfg.width) * 64'(frame_cfg.height);
		if (64'(full_addr) >= frame_size || full_addr > 32'hFF_FFFF)
			return 1'b0;
		px.addr  = full_addr[ADDR_W-1:0];
		px.value = word[11:0];
		return 1'b1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// starts and ends at a falling edge
	task automatic send_byte(input logic sof, input logic [BYTE_W-1:0] b,
		input exp_kind_t kind, input addr_pixel_t typed);
		int          gap;
		addr_pixel_t px;
		bit          hit;
		if (send_count % 40 == 0)
			send_burst = ($urandom_range(0, 3) == 0);
		send_count++;
		gap = send_burst ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_bus.valid          <= 1'b1;
		in_bus.data_byte      <= b;
		in_bus.start_of_frame <= sof;
		do @(posedge clk); while (!in_bus.ready);
		hit = descramble_byte(sof, b, px);
		case (kind)
			EXP_MODEL: if (hit) pending_pixels.push_back(px);
			EXP_PIXEL: pending_pixels.push_back(typed);
			default: ;
		endcase
		bytes_sent++;
		@(negedge clk);
	endtask

	// waits out the output queue and any byte still in flight
	task automatic drain_pipeline();
		in_bus.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// leaves the bus selected, the caller closes the transfer
	task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_WIDTH:  frame_cfg.width  = value[WIDTH_W-1:0];
			REG_HEIGHT: frame_cfg.height = value[HEIGHT_W-1:0];
			REG_MODE:   frame_cfg.mode   = value[MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input cfg_t setting);
		write_register(REG_WIDTH, 32'(setting.width));
		write_register(REG_HEIGHT, 32'(setting.height));
		write_register(REG_MODE, 32'(setting.mode));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	task automatic push_word(input logic sof, input logic [15:0] word);
		stream_bytes.push_back('{sof, word[7:0]});
		stream_bytes.push_back('{1'b0, word[15:8]});
	endtask

	task automatic build_stream(input int count);
		int               r;
		logic             next_sof;
		logic [NIB_W-1:0] nib;
		logic [11:0]      low;
		next_sof = 1'b1;
		stream_bytes.delete();
		while (stream_bytes.size() < count) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				next_sof = 1'b1;
			end else if (r < 12) begin
				// stray byte, followed by a fresh frame half of the time
				stream_bytes.push_back('{next_sof, 8'($urandom_range(0, 255))});
				next_sof = ($urandom_range(0, 1) == 1);
			end else if (r < 28) begin
				nib = ($urandom_range(0, 1) == 1) ? NIB_ROW_A : NIB_ROW_B;
				r = $urandom_range(0, 9);
				if (r < 2)
					low = frame_cfg.height - 1'b1;
				else if (r < 8)
					low = 12'($urandom_range(0, frame_cfg.height - 1));
				else
					low = 12'($urandom_range(0, 4095));
				push_word(next_sof, {nib, low});
				next_sof = 1'b0;
			end else if (r < 33) begin
				push_word(next_sof, {NIB_SKIP, 12'($urandom_range(0, 4095))});
				next_sof = 1'b0;
			end else begin
				nib = 4'($urandom_range(0, 12));
				if (nib >= 4'd10)
					nib = nib + 1'b1;
				r = $urandom_range(0, 9);
				low = (r == 0) ? 12'h000 : (r == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
				push_word(next_sof, {nib, low});
				next_sof = 1'b0;
			end
		end
	endtask

	task automatic run_stream();
		foreach (stream_bytes[i])
			send_byte(stream_bytes[i].sof, stream_bytes[i].data, EXP_MODEL, '0);
	endtask

	initial begin
		cfg_t setting;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		in_bus.valid          = 1'b0;
		in_bus.data_byte      = '0;
		in_bus.start_of_frame = 1'b0;
		frame_cfg             = '{WIDTH_RESET, HEIGHT_RESET, MODE_RESET};
		held_byte             = '0;
		high_phase            = 1'b0;
		col_count             = '0;
		cur_row               = '0;
		errors                = 0;
		bytes_sent            = 0;
		settings_used         = 1;
		send_count            = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(DIRECTED[i].sof, DIRECTED[i].data, DIRECTED[i].kind,
				'{DIRECTED[i].addr, DIRECTED[i].value});
		build_stream(STREAM_BYTES);
		run_stream();

		for (int p = 0; p < PHASES - 1; p++) begin
			drain_pipeline();
			if (p < FIXED_SETTINGS) begin
				setting = FIXED_CFG[p];
			end else begin
				setting.width  = ($urandom_range(0, 1) == 1) ? 13'($urandom_range(1, 16))
					: 13'($urandom_range(1, 4096));
				setting.height = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(1, 16))
					: 12'($urandom_range(1, 4095));
				setting.mode   = ($urandom_range(0, 1) == 1) ? MODE_INTERLEAVE
					: 4'($urandom_range(0, 15));
			end
			configure(setting);
			build_stream(STREAM_BYTES);
			run_stream();
		end
		drain_pipeline();

		$display("streamed %0d bytes under %0d frame settings, %0d pixels compared",
			bytes_sent, settings_used, pixels_seen);
		if (errors == 0)
			$display("** sensor_row_marker_descrambler_unit: PASSED **");
		else
			$display("** sensor_row_marker_descrambler_unit: FAILED **");
		$finish;
	end

	// pixel side: random idling plus one long hold-off
	initial begin
		int gap;
		out_bus.ready = 1'b0;
		held_off      = 1'b0;
		recv_count    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && pixels_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (recv_count % 40 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			recv_count++;
			gap = recv_burst ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				out_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_bus.ready <= 1'b1;
			do @(posedge clk); while (!out_bus.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: pixel_address %0d pixel_value %0h",
					out_bus.pixel_address, out_bus.pixel_value);
				errors++;
			end else begin
				oldest_pixel = pending_pixels.pop_front();
				if (out_bus.pixel_address !== oldest_pixel.addr) begin
					$error("pixel_address: expected %0d, actual %0d",
						oldest_pixel.addr, out_bus.pixel_address);
					errors++;
				end
				if (out_bus.pixel_value !== oldest_pixel.value) begin
					$error("pixel_value: expected %0h, actual %0h",
						oldest_pixel.value, out_bus.pixel_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no request moved for %0d cycles, %0d pixels outstanding",
				idle_cycles, pending_pixels.size());
			$display("** sensor_row_marker_descrambler_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		pixels_seen = 0;
		idle_cycles = 0;
		send_burst  = 1'b0;
		recv_burst  = 1'b0;
	end

endmodule
